@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion wrappers; they expect clk and rst_n in the calling scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks a property at every clock edge outside reset.
`define PFP_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pfp assertion failed");
// Checks that a condition in one cycle is followed by another in the next.
`define PFP_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pfp assertion failed");
`else
`define PFP_ASSERT(label, prop)
`define PFP_ASSERT_NEXT(label, pre, post)
`endif
`endif

@@ rtl/pfp_pkg.sv @@
// ----------------------------------------------------------------------------
// pfp_pkg
// Widths, register codes and shared types of the per-flow policer.
// ----------------------------------------------------------------------------
package pfp_pkg;

    localparam int ID_W       = 12;
    localparam int RATE_W     = 8;
    localparam int BURST_W    = 24;
    localparam int TIME_W     = 64;
    localparam int LEN_W      = 16;
    localparam int PROD_W     = TIME_W + RATE_W;
    localparam int CFG_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [RATE_W-1:0]  RATE_RESET  = 8'd12;
    localparam logic [BURST_W-1:0] BURST_RESET = 24'h10_0000;

    // Register selected by bit 2 of the byte address.
    typedef enum logic {
        REG_RATE  = 1'b0,
        REG_BURST = 1'b1
    } reg_idx_t;

    // One row of the bucket table.
    typedef struct packed {
        logic               valid;
        logic [BURST_W-1:0] level;
        logic [TIME_W-1:0]  last_time;
    } row_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic load;
        logic rd_en;
        logic elapse;
        logic mult;
        logic tokens;
        logic finish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic police_in;
        logic out_free;
    } dp_status_t;

endpackage

@@ rtl/pfp_in_if.sv @@
// ----------------------------------------------------------------------------
// pfp_in_if
// Packet descriptor channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pfp_in_if
    import pfp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   flow_id;
    logic              flow_known;
    logic [TIME_W-1:0] arrival_time;
    logic [LEN_W-1:0]  packet_length;

    modport source (
        output valid, flow_id, flow_known, arrival_time, packet_length,
        input  ready
    );
    modport sink (
        input  valid, flow_id, flow_known, arrival_time, packet_length,
        output ready
    );
endinterface

@@ rtl/pfp_out_if.sv @@
// ----------------------------------------------------------------------------
// pfp_out_if
// Policing verdict channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pfp_out_if;
    logic valid;
    logic ready;
    logic verdict;
    logic new_flow;

    modport source (
        output valid, verdict, new_flow,
        input  ready
    );
    modport sink (
        input  valid, verdict, new_flow,
        output ready
    );
endinterface

@@ rtl/pfp_ram.sv @@
// ----------------------------------------------------------------------------
// pfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/pfp_ctrl.sv @@
// ----------------------------------------------------------------------------
// pfp_ctrl
// Sequencer of the policer: table clear, then one request at a time.
// ----------------------------------------------------------------------------
module pfp_ctrl
    import pfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_READ   = 7'b0000100,
        ST_ELAPSE = 7'b0001000,
        ST_MULT   = 7'b0010000,
        ST_TOKENS = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    // Requests that are not policed skip the table walk.
                    state_next = status.police_in ? ST_READ : ST_FINISH;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_ELAPSE;
            end
            ST_ELAPSE:
            begin
                cmd.elapse = 1'b1;
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = ST_TOKENS;
            end
            ST_TOKENS:
            begin
                cmd.tokens = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/pfp_dp.sv @@
// ----------------------------------------------------------------------------
// pfp_dp
// Policer datapath: bucket table, refill arithmetic and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfp_dp
    import pfp_pkg::*;
#(
    parameter int FLOW_COUNT = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    input  logic [ID_W-1:0]    flow_id,
    input  logic               flow_known,
    input  logic [TIME_W-1:0]  arrival_time,
    input  logic [LEN_W-1:0]   packet_length,
    input  logic [RATE_W-1:0]  refill_rate,
    input  logic [BURST_W-1:0] burst_size,
    input  logic               out_ready,
    output logic               out_valid,
    output logic               verdict,
    output logic               new_flow
);

    localparam int IDX_W = $clog2(FLOW_COUNT);
    localparam int CMP_W = ((ID_W > IDX_W) ? ID_W : IDX_W) + 1;
    localparam int ROW_W = $bits(row_t);

    logic [CMP_W-1:0]   id_ext;
    logic               police_in;

    logic [IDX_W-1:0]   clr_cnt_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               police_reg;
    logic               hit_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [BURST_W-1:0] level_reg;
    logic [TIME_W-1:0]  elapsed_reg;
    logic [PROD_W-1:0]  product_reg;
    logic [BURST_W-1:0] tokens_reg;
    logic [BURST_W-1:0] tokens_next;
    logic               out_valid_reg;
    logic               verdict_reg;
    logic               new_flow_reg;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ROW_W-1:0]   ram_wdata;
    logic [ROW_W-1:0]   ram_rdata;
    row_t               rd_row;
    row_t               wr_row;

    logic               refill_over;
    logic [BURST_W-1:0] refill_low;
    logic [BURST_W:0]   level_sum;
    logic [BURST_W-1:0] len_ext;
    logic               conform;
    logic [BURST_W-1:0] level_new;

    // Flow ids past the end of the table pass unpoliced.
    assign id_ext    = CMP_W'(flow_id);
    assign police_in = flow_known && (id_ext < CMP_W'(FLOW_COUNT));

    assign status.police_in  = police_in;
    assign status.clear_last = (clr_cnt_reg == IDX_W'(FLOW_COUNT - 1));
    assign status.out_free   = !out_valid_reg || out_ready;

    pfp_ram #(
        .WIDTH (ROW_W),
        .DEPTH (FLOW_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_row = row_t'(ram_rdata);

    // Refill: any product bit at or above the burst width means the bucket
    // fills completely, which also covers the largest 72-bit product.
    assign refill_over = |product_reg[PROD_W-1:BURST_W];
    assign refill_low  = product_reg[BURST_W-1:0];
    assign level_sum   = {1'b0, level_reg} + {1'b0, refill_low};

    always_comb
    begin
        if (refill_over || (refill_low >= burst_size))
        begin
            tokens_next = burst_size;
        end
        else if (level_sum > {1'b0, burst_size})
        begin
            tokens_next = burst_size;
        end
        else
        begin
            tokens_next = level_sum[BURST_W-1:0];
        end
    end

    assign len_ext   = BURST_W'(len_reg);
    assign conform   = (tokens_reg >= len_ext);
    assign level_new = conform ? (tokens_reg - len_ext) : tokens_reg;

    always_comb
    begin
        wr_row.valid     = 1'b1;
        wr_row.last_time = now_reg;
        wr_row.level     = hit_reg ? level_new : burst_size;
    end

    assign ram_we    = cmd.clear || (cmd.finish && police_reg);
    assign ram_waddr = cmd.clear ? clr_cnt_reg : idx_reg;
    assign ram_wdata = cmd.clear ? '0 : ROW_W'(wr_row);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            police_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.load)
            begin
                police_reg <= police_in;
            end
            if (cmd.elapse)
            begin
                hit_reg <= rd_row.valid;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg <= id_ext[IDX_W-1:0];
            now_reg <= arrival_time;
            len_reg <= packet_length;
        end
        if (cmd.elapse)
        begin
            level_reg   <= rd_row.level;
            elapsed_reg <= now_reg - rd_row.last_time;
        end
        if (cmd.mult)
        begin
            product_reg <= PROD_W'(elapsed_reg) * PROD_W'(refill_rate);
        end
        if (cmd.tokens)
        begin
            tokens_reg <= tokens_next;
        end
        if (cmd.finish)
        begin
            verdict_reg  <= police_reg && hit_reg && !conform;
            new_flow_reg <= police_reg && !hit_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;
    assign new_flow  = new_flow_reg;

    `PFP_ASSERT(a_one_cmd, $onehot0(cmd))
    `PFP_ASSERT(a_finish_free, !cmd.finish || !out_valid_reg || out_ready)
    `PFP_ASSERT_NEXT(a_tokens_cap, cmd.tokens, tokens_reg <= burst_size)
    `PFP_ASSERT_NEXT(a_clear_quiet, cmd.clear, !out_valid_reg && !cmd.finish)

endmodule

@@ rtl/per_flow_token_bucket_policer_top.sv @@
// ----------------------------------------------------------------------------
// per_flow_token_bucket_policer_top
// Per-flow token bucket policer with an APB-style configuration port.
// ----------------------------------------------------------------------------
// Usage. Packet descriptors arrive on in_ch (flow id, known flag, arrival time
// in ns, length in bytes); one verdict per request leaves on out_ch, in the
// order the requests were taken. Both channels move a request when valid and
// ready are high at a rising edge of clk.
// A policed request walks the bucket table step by step: accept, table read,
// elapsed time, refill multiply, token cap, then charge and write back, which
// loads the result register. The next request can be taken only once the
// previous one has finished. An unknown or out-of-range flow needs only the
// accept and result steps and touches no table state. The controller handles
// one request at a time, which sets the request rate.
// Reset clears the configuration to rate 12 and burst 2^20 and then sweeps the
// bucket table, one row per cycle, over FLOW_COUNT rows; in_ch.ready stays low
// during the sweep, while configuration writes are taken as usual.
// A finished verdict sits in an output register, so a stalled receiver does
// not stop the next request from being accepted; the block only waits at its
// final step, write-back or result, until that register is free.
// ----------------------------------------------------------------------------
module per_flow_token_bucket_policer_top
    import pfp_pkg::*;
#(
    parameter int FLOW_COUNT = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    pfp_in_if.sink                in_ch,
    pfp_out_if.source             out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [RATE_W-1:0]  rate_reg;
    logic [BURST_W-1:0] burst_reg;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;

    dp_cmd_t            cmd;
    dp_status_t         status;

    // Configuration registers. The register is picked by address bit 2, so
    // every write lands in one of the two registers.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= RATE_RESET;
            burst_reg <= BURST_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_RATE:  rate_reg  <= pwdata[RATE_W-1:0];
                REG_BURST: burst_reg <= pwdata[BURST_W-1:0];
                default:   rate_reg  <= rate_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_RATE:  prdata = APB_DATA_W'(rate_reg);
            REG_BURST: prdata = APB_DATA_W'(burst_reg);
            default:   prdata = '0;
        endcase
    end

    // The controller sequences each request through the datapath stages.
    pfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath owns the bucket table and the result register.
    pfp_dp #(
        .FLOW_COUNT (FLOW_COUNT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .flow_id       (in_ch.flow_id),
        .flow_known    (in_ch.flow_known),
        .arrival_time  (in_ch.arrival_time),
        .packet_length (in_ch.packet_length),
        .refill_rate   (rate_reg),
        .burst_size    (burst_reg),
        .out_ready     (out_ch.ready),
        .out_valid     (out_ch.valid),
        .verdict       (out_ch.verdict),
        .new_flow      (out_ch.new_flow)
    );

endmodule
